### rtl/tlb_page_walker_unit_defines.svh
// Assertion macros used by the walk sequencer of the page walker RTL
`ifndef TLB_PAGE_WALKER_UNIT_DEFINES_SVH
`define TLB_PAGE_WALKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define TPW_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("page walker check failed");
`define TPW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("page walker check failed");
`else
`define TPW_ASSERT_NOW(label, clk, rst, ante, cons)
`define TPW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/tlbpw_pkg.sv
// Types and constants of the page walker
`default_nettype none
package tlbpw_pkg;

  localparam int unsigned ADDR_W              = 32;
  localparam int unsigned VPN_W               = 20;
  localparam int unsigned OFF_W               = 12;
  localparam int unsigned DIR_IDX_W           = 10;
  localparam int unsigned PADDR_W             = 4;
  localparam int unsigned PRESENT_BIT         = 0;
  localparam int unsigned DEFAULT_TLB_ENTRIES = 64;

  typedef enum logic {
    OP_TRANSLATE = 1'b0,
    OP_RESPONSE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_PHYS  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_FAULT = 2'd2,
    KIND_PROTO = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PHASE_IDLE  = 2'd0,
    PHASE_DIR   = 2'd1,
    PHASE_TABLE = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    REG_PROTECT  = 2'd0,
    REG_PAGING   = 2'd1,
    REG_DIR_BASE = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic             prot_mode;
    logic             paging_enable;
    logic [VPN_W-1:0] dir_base_frame;
  } cfg_t;

  typedef struct packed {
    logic             hit;
    logic [VPN_W-1:0] frame;
  } tlb_look_t;

  typedef struct packed {
    logic             en;
    logic [VPN_W-1:0] vpage;
    logic [VPN_W-1:0] frame;
  } tlb_fill_t;

endpackage
`default_nettype wire

### rtl/tlbpw_regs.sv
// Configuration registers behind the APB port
`default_nettype none
module tlbpw_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tlbpw_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output tlbpw_pkg::cfg_t                    cfg
);
  import tlbpw_pkg::*;

  cfg_t     cfg_q;
  reg_idx_t idx;
  logic     wr;

  assign idx = reg_idx_t'(paddr[3:2]);
  assign wr  = psel & penable & pwrite;
  assign cfg = cfg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q <= '0;
    end else if (wr) begin
      case (idx)
        REG_PROTECT:  cfg_q.prot_mode      <= pwdata[0];
        REG_PAGING:   cfg_q.paging_enable  <= pwdata[0];
        REG_DIR_BASE: cfg_q.dir_base_frame <= pwdata[VPN_W-1:0];
        default:      cfg_q <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PROTECT:  prdata = {31'd0, cfg_q.prot_mode};
      REG_PAGING:   prdata = {31'd0, cfg_q.paging_enable};
      REG_DIR_BASE: prdata = {{(32-VPN_W){1'b0}}, cfg_q.dir_base_frame};
      default:      prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

### rtl/tlbpw_cam.sv
// Fully associative TLB: entry storage, lowest-index match and round-robin fill
`default_nettype none
module tlbpw_cam #(
  parameter int unsigned ENTRIES = tlbpw_pkg::DEFAULT_TLB_ENTRIES
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [tlbpw_pkg::VPN_W-1:0] lookup_vpage,
  output tlbpw_pkg::tlb_look_t             look,
  input  wire tlbpw_pkg::tlb_fill_t        fill
);
  import tlbpw_pkg::*;

  localparam int unsigned PTR_W = $clog2(ENTRIES);

  logic [VPN_W-1:0] vpage_q [ENTRIES];
  logic [VPN_W-1:0] frame_q [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  logic [PTR_W-1:0]   fill_ptr_q;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] first;
  logic [VPN_W-1:0]   frame_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q    <= '0;
      fill_ptr_q <= '0;
    end else if (fill.en) begin
      valid_q[fill_ptr_q] <= 1'b1;
      fill_ptr_q <= (fill_ptr_q == PTR_W'(ENTRIES - 1)) ? '0 : fill_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fill.en) begin
      vpage_q[fill_ptr_q] <= fill.vpage;
      frame_q[fill_ptr_q] <= fill.frame;
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_q[i] && (vpage_q[i] == lookup_vpage);
    end
  end

  assign first = match & (~match + 1'b1);

  always_comb begin
    frame_sel = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      frame_sel = frame_sel | ({VPN_W{first[i]}} & frame_q[i]);
    end
  end

  assign look.hit   = |match;
  assign look.frame = frame_sel;

endmodule
`default_nettype wire

### rtl/tlbpw_walk.sv
// Walk sequencer: bypass, hit answer, directory and table steps, fill request
`default_nettype none
`include "tlb_page_walker_unit_defines.svh"
module tlbpw_walk (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         step,
  input  wire logic                         op,
  input  wire logic [tlbpw_pkg::ADDR_W-1:0] lin,
  input  wire logic [tlbpw_pkg::ADDR_W-1:0] word,
  input  wire tlbpw_pkg::cfg_t              cfg,
  input  wire tlbpw_pkg::tlb_look_t         look,
  output tlbpw_pkg::tlb_fill_t              fill,
  output tlbpw_pkg::kind_t                  kind,
  output logic      [tlbpw_pkg::ADDR_W-1:0] addr
);
  import tlbpw_pkg::*;

  phase_t            phase_q;
  phase_t            phase_next;
  logic [ADDR_W-1:0] pend_q;
  logic [ADDR_W-1:0] pend_next;
  op_t               opc;
  logic              bypass;
  logic              present;

  assign opc     = op_t'(op);
  assign bypass  = ~(cfg.prot_mode & cfg.paging_enable);
  assign present = word[PRESENT_BIT];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_q <= PHASE_IDLE;
    end else begin
      phase_q <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_q <= pend_next;
  end

  always_comb begin
    phase_next = phase_q;
    pend_next  = pend_q;
    if (step) begin
      case (phase_q)
        PHASE_IDLE: begin
          if (opc == OP_TRANSLATE && !bypass && !look.hit) begin
            phase_next = PHASE_DIR;
            pend_next  = lin;
          end
        end
        PHASE_DIR: begin
          if (opc == OP_RESPONSE) begin
            phase_next = present ? PHASE_TABLE : PHASE_IDLE;
          end
        end
        PHASE_TABLE: begin
          if (opc == OP_RESPONSE) begin
            phase_next = PHASE_IDLE;
          end
        end
        default: phase_next = PHASE_IDLE;
      endcase
    end
  end

  always_comb begin
    kind = KIND_PROTO;
    addr = '0;
    fill = '0;
    case (phase_q)
      PHASE_IDLE: begin
        if (opc == OP_TRANSLATE) begin
          if (bypass) begin
            kind = KIND_PHYS;
            addr = lin;
          end else if (look.hit) begin
            kind = KIND_PHYS;
            addr = {look.frame, lin[OFF_W-1:0]};
          end else begin
            kind = KIND_READ;
            addr = {cfg.dir_base_frame, lin[ADDR_W-1 -: DIR_IDX_W], 2'b00};
          end
        end
      end
      PHASE_DIR: begin
        if (opc == OP_RESPONSE) begin
          if (!present) begin
            kind = KIND_FAULT;
            addr = pend_q;
          end else begin
            kind = KIND_READ;
            addr = {word[ADDR_W-1:OFF_W], pend_q[OFF_W +: DIR_IDX_W], 2'b00};
          end
        end
      end
      PHASE_TABLE: begin
        if (opc == OP_RESPONSE) begin
          if (!present) begin
            kind = KIND_FAULT;
            addr = pend_q;
          end else begin
            kind       = KIND_PHYS;
            addr       = {word[ADDR_W-1:OFF_W], pend_q[OFF_W-1:0]};
            fill.en    = step;
            fill.vpage = pend_q[ADDR_W-1:OFF_W];
            fill.frame = word[ADDR_W-1:OFF_W];
          end
        end
      end
      default: begin
        kind = KIND_PROTO;
      end
    endcase
  end

  `TPW_ASSERT_NOW(a_fill_only_on_table, clk, rst, fill.en, step && phase_q == PHASE_TABLE)
  `TPW_ASSERT_NEXT(a_read_opens_walk, clk, rst, step && kind == KIND_READ, phase_q != PHASE_IDLE)
  `TPW_ASSERT_NEXT(a_table_closes_walk, clk, rst, step && phase_q == PHASE_TABLE && opc == OP_RESPONSE, phase_q == PHASE_IDLE)
  `TPW_ASSERT_NEXT(a_proto_keeps_phase, clk, rst, step && kind == KIND_PROTO, $stable(phase_q))

endmodule
`default_nettype wire

### rtl/tlb_page_walker_unit.sv
// Top level of the page walker: item registers, TLB, walk sequencer, APB registers
//
//  channel | dir | handshake              | payload
//  s_*     | in  | s_tvalid / s_tready    | s_tuser opcode, s_tdata linear_address, memory_word
//  m_*     | out | m_tvalid / m_tready    | m_tuser kind, m_tdata address_out
//  apb     | in  | psel, penable, pwrite  | paddr, pwdata, prdata (pready tied high)
//
//  One item per cycle sustained while m_tready holds; each item passes the input register, then the output register.
//  The combinational path between registers is the parallel TLB compare plus the walk decision.
//  Reset clears TLB valid bits, fill pointer and walk phase directly; no sweep.
//  A stalled result holds in the output register; the input register still takes
//  a new item, and further items wait only while both registers are full.
`default_nettype none
module tlb_page_walker_unit #(
  parameter int unsigned TLB_ENTRIES = tlbpw_pkg::DEFAULT_TLB_ENTRIES
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [63:0]                   s_tdata,  // [31:0] linear_address, [63:32] memory_word
  input  wire logic                          s_tuser,  // [0] opcode
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [31:0]                   m_tdata,  // [31:0] address_out
  output logic      [1:0]                    m_tuser,  // [1:0] kind
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tlbpw_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);
  import tlbpw_pkg::*;

  logic              in_valid_q;
  logic              in_op_q;
  logic [ADDR_W-1:0] in_lin_q;
  logic [ADDR_W-1:0] in_word_q;
  logic              out_valid_q;
  kind_t             out_kind_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic              step;
  logic              take;
  cfg_t              cfg;
  tlb_look_t         look;
  tlb_fill_t         fill;
  kind_t             kind;
  logic [ADDR_W-1:0] addr;

  assign pready   = 1'b1;
  assign step     = in_valid_q & (~out_valid_q | m_tready);
  assign s_tready = ~in_valid_q | step;
  assign take     = s_tvalid & s_tready;
  assign m_tvalid = out_valid_q;
  assign m_tdata  = out_addr_q;
  assign m_tuser  = out_kind_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (s_tready) begin
      in_valid_q <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_op_q   <= s_tuser;
      in_lin_q  <= s_tdata[31:0];
      in_word_q <= s_tdata[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (~out_valid_q | m_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_kind_q <= kind;
      out_addr_q <= addr;
    end
  end

  tlbpw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  tlbpw_cam #(
    .ENTRIES (TLB_ENTRIES)
  ) u_cam (
    .clk          (clk),
    .rst          (rst),
    .lookup_vpage (in_lin_q[ADDR_W-1:OFF_W]),
    .look         (look),
    .fill         (fill)
  );

  tlbpw_walk u_walk (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .op   (in_op_q),
    .lin  (in_lin_q),
    .word (in_word_q),
    .cfg  (cfg),
    .look (look),
    .fill (fill),
    .kind (kind),
    .addr (addr)
  );

endmodule
`default_nettype wire
